// File: rtl/sfs_pkg.sv
package sfs_pkg;

  // default sizes
  localparam int NUM_ANIMS_DEF  = 16;
  localparam int MAX_FRAMES_DEF = 256;
  localparam int MAX_STEPS_DEF  = 16;

  // field widths
  localparam int FUNC_W  = 3;
  localparam int CODE_W  = 3;
  localparam int ANIM_W  = 4;
  localparam int FRAME_W = 8;
  localparam int COUNT_W = 9;
  localparam int TIME_W  = 32;
  localparam int FLAG_W  = 8;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 32;
  localparam int NANIM_W = 5;
  localparam int RATE_W  = 16;

  // item functions
  localparam logic [FUNC_W-1:0] FN_TICK      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CTRL      = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SELECT    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SET_FRAME = 3'd3;
  localparam logic [FUNC_W-1:0] FN_LOAD      = 3'd4;

  // control codes
  localparam logic [CODE_W-1:0] CC_PLAY     = 3'd0;
  localparam logic [CODE_W-1:0] CC_PAUSE    = 3'd1;
  localparam logic [CODE_W-1:0] CC_REVERSE  = 3'd2;
  localparam logic [CODE_W-1:0] CC_RESET    = 3'd3;
  localparam logic [CODE_W-1:0] CC_LOOP     = 3'd4;
  localparam logic [CODE_W-1:0] CC_NOLOOP   = 3'd5;
  localparam logic [CODE_W-1:0] CC_BOUNCE   = 3'd6;
  localparam logic [CODE_W-1:0] CC_NOBOUNCE = 3'd7;

  // register indexes
  localparam logic [CFG_A_W-1:0] CFG_NUM_ANIMS = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_STEP_TIME = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_PLAY_RATE = 2'd2;

  localparam logic [NANIM_W-1:0] NUM_ANIMS_RST = 5'd1;
  localparam logic [TIME_W-1:0]  STEP_TIME_RST = 32'd1092;
  localparam logic [RATE_W-1:0]  PLAY_RATE_RST = 16'd256;

  // flag word bit positions
  localparam int FL_PAUSED   = 0;
  localparam int FL_REVERSE  = 1;
  localparam int FL_LOOP     = 2;
  localparam int FL_BOUNCE   = 3;
  localparam int FL_BOUNCING = 4;
  localparam int FL_KEEPFWD  = 5;
  localparam int FL_NOLOOP   = 6;
  localparam int FL_NOBOUNCE = 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_ADD,
    S_STEP,
    S_WRITE,
    S_FINISH
  } seq_state_t;

endpackage

// File: rtl/sfs_if.sv
interface sfs_cmd_if;
  import sfs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [CODE_W-1:0]    ctrl_code;
  logic [ANIM_W-1:0]    target_anim;
  logic [FRAME_W-1:0]   frame_index;
  logic [COUNT_W-1:0]   frame_count;
  logic [TIME_W-1:0]    frame_duration;
  logic                 default_loop;
  logic                 default_bounce;
  logic                 default_reverse;

  modport source (output valid, func, ctrl_code, target_anim, frame_index, frame_count,
                  frame_duration, default_loop, default_bounce, default_reverse,
                  input ready);
  modport sink (input valid, func, ctrl_code, target_anim, frame_index, frame_count,
                frame_duration, default_loop, default_bounce, default_reverse,
                output ready);
endinterface

interface sfs_rsp_if;
  import sfs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ANIM_W-1:0]    current_anim;
  logic [FRAME_W-1:0]   current_frame;
  logic                 is_paused;
  logic                 is_finished;
  logic                 rejected;

  modport source (output valid, current_anim, current_frame, is_paused, is_finished,
                  rejected, input ready);
  modport sink (input valid, current_anim, current_frame, is_paused, is_finished,
                rejected, output ready);
endinterface

interface sfs_cfg_if;
  import sfs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_A_W-1:0]   addr;
  logic [CFG_D_W-1:0]   data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// File: rtl/sfs_ram.sv
module sfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sprite_frame_sequencer_unit.sv
// Sprite frame sequencer: per-animation flags live in a small synchronous RAM and are
// read once per transaction and written back by ticks and in-range control and load
// commands; the current animation, frame and elapsed time sit in registers. One
// command is in flight at a time. Every command passes through the read, write and
// finish states; a tick also runs the multiply, add and step states (only step when
// paused), making at most MAX_STEPS_PER_TICK frame steps, one per cycle through the
// duration compare and subtract. The step_time * play_rate product is registered in
// the multiply state and the saturating time add in the add state. The flag RAM
// starts all zero through valid bits cleared by reset, so no clearing pass is needed.
// A finished result waits in the output register while the next command is accepted.
module sprite_frame_sequencer_unit
  import sfs_pkg::*;
#(
  parameter int NUM_ANIMS          = NUM_ANIMS_DEF,
  parameter int MAX_FRAMES         = MAX_FRAMES_DEF,
  parameter int MAX_STEPS_PER_TICK = MAX_STEPS_DEF
) (
  input logic      clk,
  input logic      rst,
  sfs_cmd_if.sink  cmd,
  sfs_rsp_if.source rsp,
  sfs_cfg_if.sink  cfg
);

  localparam int ANIM_LIM  = (NUM_ANIMS < 16) ? NUM_ANIMS : 16;
  localparam int FRAME_LIM = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
  localparam int AW        = (ANIM_LIM > 1) ? $clog2(ANIM_LIM) : 1;
  localparam int KW        = $clog2(MAX_STEPS_PER_TICK + 1);
  localparam logic [NANIM_W-1:0] ANIM_LIM_C  = NANIM_W'(ANIM_LIM);
  localparam logic [COUNT_W-1:0] FRAME_LIM_C = COUNT_W'(FRAME_LIM);
  localparam logic [KW-1:0]      STEPS_C     = KW'(MAX_STEPS_PER_TICK);

  typedef struct packed {
    logic [FLAG_W-1:0]  flags;
    logic [FRAME_W-1:0] frame;
  } step_res_t;

  function automatic step_res_t step_once(input logic [FLAG_W-1:0] f,
                                          input logic [FRAME_W-1:0] fr,
                                          input logic [COUNT_W-1:0] n);
    logic signed [10:0] nx;
    logic signed [10:0] nn;
    logic [FLAG_W-1:0]  g;
    step_res_t          r;
    g  = f;
    nn = $signed({2'b00, n});
    if (!f[FL_REVERSE]) begin
      nx = $signed({3'b000, fr}) + (f[FL_BOUNCING] ? -11'sd1 : 11'sd1);
      if (nx < 11'sd0) begin
        if (f[FL_LOOP]) begin
          g[FL_BOUNCING] = 1'b0;
          nx = 11'sd1;
        end else begin
          nx = 11'sd0;
        end
      end else if (nx >= nn) begin
        if (f[FL_BOUNCE]) begin
          g[FL_BOUNCING] = 1'b1;
          nx = nn - 11'sd2;
        end else if (f[FL_LOOP]) begin
          nx = 11'sd0;
        end else begin
          nx = nn - 11'sd1;
        end
      end
    end else begin
      nx = $signed({3'b000, fr}) + (f[FL_BOUNCING] ? 11'sd1 : -11'sd1);
      if (nx < 11'sd0) begin
        if (f[FL_BOUNCE]) begin
          g[FL_BOUNCING] = 1'b1;
          nx = 11'sd1;
        end else if (f[FL_LOOP]) begin
          nx = nn - 11'sd1;
        end else begin
          nx = 11'sd0;
        end
      end else if (nx >= nn) begin
        if (f[FL_LOOP]) begin
          g[FL_BOUNCING] = 1'b0;
          nx = nn - 11'sd2;
        end else begin
          nx = nn - 11'sd1;
        end
      end
    end
    // negative targets and one-frame animations clamp into range
    if (nx < 11'sd0) begin
      nx = 11'sd0;
    end else if (nx > nn - 11'sd1) begin
      nx = nn - 11'sd1;
    end
    r.flags = g;
    r.frame = nx[FRAME_W-1:0];
    return r;
  endfunction

  // configuration
  logic [NANIM_W-1:0] num_anims;
  logic [TIME_W-1:0]  step_time;
  logic [RATE_W-1:0]  play_rate;

  // sequencer state
  seq_state_t         state, state_next;
  logic [ANIM_W-1:0]  anim_now, anim_next;
  logic [FRAME_W-1:0] frame_now, frame_next;
  logic [TIME_W-1:0]  elapsed_time, elapsed_next;
  logic [ANIM_LIM-1:0] vld;

  // working registers
  logic [FLAG_W-1:0]  flags, flags_next;
  logic [KW-1:0]      k, k_next;
  logic [47:0]        prod, prod_next;
  logic               wr, wr_next;
  logic               cok, cok_next;
  logic               rej, rej_next;
  logic               fwd, fwd_next;

  // latched command
  logic [FUNC_W-1:0]  func_q;
  logic [CODE_W-1:0]  code_q;
  logic [ANIM_W-1:0]  tgt_q;
  logic [FRAME_W-1:0] fi_q;
  logic [COUNT_W-1:0] n_q;
  logic [TIME_W-1:0]  dur_q;
  logic               dl_q, db_q, dr_q;
  logic [AW-1:0]      addr_q;

  // result register
  logic               result_valid;
  logic [ANIM_W-1:0]  res_anim;
  logic [FRAME_W-1:0] res_frame;
  logic               res_paused, res_finished, res_rejected;

  // combinational helpers
  logic               cmd_fire;
  logic               reads_tgt;
  logic [COUNT_W-1:0] cnt_in;
  logic [AW-1:0]      sel_addr;
  logic [AW-1:0]      mem_raddr;
  logic [FLAG_W-1:0]  mem_rdata;
  logic               mem_we;
  logic [NANIM_W-1:0] na, na_m1;
  logic [COUNT_W-1:0] n_m1;
  logic [FLAG_W-1:0]  flags_rd, flags_cur, f_tmp;
  logic               tgt_in_tbl;
  logic [ANIM_W-1:0]  anim_clamp;
  logic [40:0]        sum;
  logic [32:0]        diff;
  step_res_t          step_r;
  logic               out_load;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_anims <= NUM_ANIMS_RST;
      step_time <= STEP_TIME_RST;
      play_rate <= PLAY_RATE_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.addr)
        CFG_NUM_ANIMS: num_anims <= cfg.data[NANIM_W-1:0];
        CFG_STEP_TIME: step_time <= cfg.data[TIME_W-1:0];
        CFG_PLAY_RATE: play_rate <= cfg.data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign reads_tgt = (cmd.func == FN_CTRL) || (cmd.func == FN_SELECT) ||
                     (cmd.func == FN_LOAD);
  assign sel_addr  = reads_tgt ? cmd.target_anim[AW-1:0] : anim_now[AW-1:0];
  assign mem_raddr = (state == S_IDLE) ? sel_addr : anim_now[AW-1:0];

  always_comb begin
    cnt_in = cmd.frame_count;
    if (cnt_in == '0) begin
      cnt_in = COUNT_W'(1);
    end else if (cnt_in > FRAME_LIM_C) begin
      cnt_in = FRAME_LIM_C;
    end
  end

  always_comb begin
    na = num_anims;
    if (na == '0) begin
      na = NANIM_W'(1);
    end else if (na > ANIM_LIM_C) begin
      na = ANIM_LIM_C;
    end
  end

  assign na_m1      = na - NANIM_W'(1);
  assign n_m1       = n_q - COUNT_W'(1);
  assign tgt_in_tbl = ({1'b0, tgt_q} < ANIM_LIM_C);
  assign anim_clamp = ({1'b0, anim_now} >= na) ? na_m1[ANIM_W-1:0] : anim_now;

  sfs_ram #(
    .WIDTH(FLAG_W),
    .DEPTH(ANIM_LIM)
  ) u_flag_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_q),
    .wdata (flags),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // entries never written read as zero
  assign flags_rd  = ((int'(addr_q) < ANIM_LIM) && vld[addr_q]) ? mem_rdata : '0;
  assign flags_cur = fwd ? flags : (vld[anim_now[AW-1:0]] ? mem_rdata : '0);

  assign sum    = {9'b0, elapsed_time} + {1'b0, prod[47:8]};
  assign diff   = {1'b0, elapsed_time} - {1'b0, dur_q};
  assign step_r = step_once(flags, frame_now, n_q);

  always_comb begin
    state_next   = state;
    anim_next    = anim_now;
    frame_next   = frame_now;
    elapsed_next = elapsed_time;
    flags_next   = flags;
    k_next       = k;
    prod_next    = prod;
    wr_next      = wr;
    cok_next     = cok;
    rej_next     = rej;
    fwd_next     = fwd;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    f_tmp        = flags_rd;
    unique case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        wr_next    = 1'b0;
        rej_next   = 1'b0;
        cok_next   = 1'b0;
        k_next     = '0;
        state_next = S_WRITE;
        unique case (func_q)
          FN_TICK: begin
            wr_next    = 1'b1;
            cok_next   = 1'b1;
            state_next = flags_rd[FL_PAUSED] ? S_STEP : S_MUL;
          end
          FN_CTRL: begin
            if (tgt_in_tbl) begin
              wr_next = 1'b1;
              unique case (code_q)
                CC_PLAY: begin
                  f_tmp[FL_PAUSED]  = 1'b0;
                  f_tmp[FL_REVERSE] = 1'b0;
                  f_tmp[FL_KEEPFWD] = 1'b1;
                end
                CC_PAUSE: f_tmp[FL_PAUSED] = 1'b1;
                CC_REVERSE: begin
                  f_tmp[FL_PAUSED]  = 1'b0;
                  f_tmp[FL_REVERSE] = 1'b1;
                end
                CC_RESET: begin
                  f_tmp[FL_BOUNCING] = 1'b0;
                  frame_next = f_tmp[FL_REVERSE] ? n_m1[FRAME_W-1:0] : '0;
                end
                CC_LOOP: f_tmp[FL_LOOP] = 1'b1;
                CC_NOLOOP: begin
                  f_tmp[FL_LOOP]   = 1'b0;
                  f_tmp[FL_NOLOOP] = 1'b1;
                end
                CC_BOUNCE: f_tmp[FL_BOUNCE] = 1'b1;
                CC_NOBOUNCE: begin
                  f_tmp[FL_BOUNCE]   = 1'b0;
                  f_tmp[FL_NOBOUNCE] = 1'b1;
                end
                default: ;
              endcase
            end
            cok_next = (tgt_q == anim_now);
          end
          FN_SELECT: begin
            if ({1'b0, tgt_q} >= na) begin
              rej_next = 1'b1;
              cok_next = (tgt_q == anim_now);
            end else begin
              cok_next = 1'b1;
              if (tgt_q != anim_now) begin
                anim_next  = tgt_q;
                frame_next = flags_rd[FL_REVERSE] ? n_m1[FRAME_W-1:0] : '0;
              end
            end
          end
          FN_SET_FRAME: begin
            cok_next = 1'b1;
            if ({1'b0, fi_q} >= n_q) begin
              rej_next = 1'b1;
            end else begin
              frame_next = fi_q;
            end
          end
          FN_LOAD: begin
            if ({1'b0, tgt_q} < na) begin
              wr_next = 1'b1;
              if (dl_q && !f_tmp[FL_NOLOOP]) f_tmp[FL_LOOP] = 1'b1;
              if (db_q && !f_tmp[FL_NOBOUNCE]) f_tmp[FL_BOUNCE] = 1'b1;
              if (dr_q && !f_tmp[FL_KEEPFWD]) f_tmp[FL_REVERSE] = 1'b1;
              anim_next = anim_clamp;
              if (tgt_q == anim_clamp && {1'b0, frame_now} >= n_q) begin
                frame_next = n_m1[FRAME_W-1:0];
              end
              cok_next = (tgt_q == anim_clamp);
            end else begin
              cok_next = (tgt_q == anim_now);
            end
          end
          default: ;
        endcase
        flags_next = f_tmp;
      end
      S_MUL: begin
        prod_next  = {16'b0, step_time} * {32'b0, play_rate};
        state_next = S_ADD;
      end
      S_ADD: begin
        elapsed_next = (|sum[40:32]) ? '1 : sum[31:0];
        state_next   = S_STEP;
      end
      S_STEP: begin
        if (k != STEPS_C && !diff[32]) begin
          flags_next   = step_r.flags;
          frame_next   = step_r.frame;
          elapsed_next = diff[31:0];
          k_next       = k + KW'(1);
        end else begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        mem_we     = wr;
        // same-edge write and read of one entry: take the written word later
        fwd_next   = wr && (addr_q == anim_now[AW-1:0]);
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!result_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      anim_now     <= '0;
      frame_now    <= '0;
      elapsed_time <= '0;
      vld          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      anim_now     <= anim_next;
      frame_now    <= frame_next;
      elapsed_time <= elapsed_next;
      if (mem_we) begin
        vld[addr_q] <= 1'b1;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (rsp.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    flags <= flags_next;
    k     <= k_next;
    prod  <= prod_next;
    wr    <= wr_next;
    cok   <= cok_next;
    rej   <= rej_next;
    fwd   <= fwd_next;
    if (cmd_fire) begin
      func_q <= cmd.func;
      code_q <= cmd.ctrl_code;
      tgt_q  <= cmd.target_anim;
      fi_q   <= cmd.frame_index;
      n_q    <= cnt_in;
      dur_q  <= (cmd.frame_duration == '0) ? TIME_W'(1) : cmd.frame_duration;
      dl_q   <= cmd.default_loop;
      db_q   <= cmd.default_bounce;
      dr_q   <= cmd.default_reverse;
      addr_q <= sel_addr;
    end
    if (out_load) begin
      res_anim     <= anim_now;
      res_frame    <= frame_now;
      res_paused   <= flags_cur[FL_PAUSED];
      res_finished <= cok && !flags_cur[FL_LOOP] &&
                      ((flags_cur[FL_REVERSE] ^ flags_cur[FL_BOUNCING]) ?
                       (frame_now == '0) : (frame_now == n_m1[FRAME_W-1:0]));
      res_rejected <= rej;
    end
  end

  assign rsp.valid         = result_valid;
  assign rsp.current_anim  = res_anim;
  assign rsp.current_frame = res_frame;
  assign rsp.is_paused     = res_paused;
  assign rsp.is_finished   = res_finished;
  assign rsp.rejected      = res_rejected;

endmodule

// File: rtl/sfs_checker.sv
module sfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [3:0] rsp_current_anim,
  input logic [7:0] rsp_current_frame,
  input logic       rsp_is_paused,
  input logic       rsp_is_finished,
  input logic       rsp_rejected
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_anim) &&
      $stable(rsp_current_frame) && $stable(rsp_is_paused) &&
      $stable(rsp_is_finished) && $stable(rsp_rejected))
    else $error("result changed while stalled");

  // one command in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted while another is in flight");

  // a new result only comes out of a busy sequencer
  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!cmd_ready))
    else $error("result raised without a command in flight");

  // no result right after acceptance: the flag RAM read is registered
  a_rsp_latency: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !$rose(rsp_valid))
    else $error("result too early after acceptance");

endmodule

bind sprite_frame_sequencer_unit sfs_checker u_sfs_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_current_anim  (rsp.current_anim),
  .rsp_current_frame (rsp.current_frame),
  .rsp_is_paused     (rsp.is_paused),
  .rsp_is_finished   (rsp.is_finished),
  .rsp_rejected      (rsp.rejected)
);

// File: tb/frame_status_monitor.sv
module frame_status_monitor
  import sfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  sfs_cmd_if                cmd,
  sfs_rsp_if                rsp,
  sfs_cfg_if                cfg,
  output int                errors,
  output int                pending,
  output logic [ANIM_W-1:0] anim_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ANIM_W-1:0]  anim;
    logic [FRAME_W-1:0] frame;
    logic               paused;
    logic               finished;
    logic               rejected;
  } frame_status_t;

  frame_status_t       status_q[$];
  logic [FLAG_W-1:0]   anim_flags[16];
  logic [FRAME_W-1:0]  frame_cur;
  logic [TIME_W-1:0]   elapsed;
  logic [NANIM_W-1:0]  anims_reg;
  logic [TIME_W-1:0]   step_reg;
  logic [RATE_W-1:0]   rate_reg;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // works out the status of the command sampled on cmd and advances the model
  function automatic frame_status_t predict_status();
    frame_status_t     st;
    logic [ANIM_W-1:0] t;
    logic [TIME_W-1:0] dur;
    logic [FLAG_W-1:0] f;
    logic [63:0]       add;
    logic [63:0]       sum;
    int                n;
    int                na;
    int                nx;
    bit                rej;
    bit                count_ok;
    bit                at_end;
    bit                at_zero;

    t = cmd.target_anim;
    n = cmd.frame_count;
    if (n == 0) n = 1;
    if (n > 256) n = 256;
    na = anims_reg;
    if (na == 0) na = 1;
    if (na > NUM_ANIMS_DEF) na = NUM_ANIMS_DEF;
    rej = 1'b0;
    count_ok = 1'b0;

    case (cmd.func)
      FN_TICK: begin
        f = anim_flags[anim_seen];
        dur = cmd.frame_duration;
        if (dur == 0) dur = 1;
        if (!f[FL_PAUSED]) begin
          add = (64'(step_reg) * 64'(rate_reg)) >> 8;
          sum = 64'(elapsed) + add;
          elapsed = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        end
        for (int k = 0; k < MAX_STEPS_DEF && elapsed >= dur; k++) begin
          nx = frame_cur;
          if (!f[FL_REVERSE]) begin
            nx += f[FL_BOUNCING] ? -1 : 1;
            if (nx < 0) begin
              if (f[FL_LOOP]) begin
                f[FL_BOUNCING] = 1'b0;
                nx = 1;
              end else nx = 0;
            end else if (nx >= n) begin
              if (f[FL_BOUNCE]) begin
                f[FL_BOUNCING] = 1'b1;
                nx = n - 2;
              end else if (f[FL_LOOP]) nx = 0;
              else nx = n - 1;
            end
          end else begin
            nx += f[FL_BOUNCING] ? 1 : -1;
            if (nx < 0) begin
              if (f[FL_BOUNCE]) begin
                f[FL_BOUNCING] = 1'b1;
                nx = 1;
              end else if (f[FL_LOOP]) nx = n - 1;
              else nx = 0;
            end else if (nx >= n) begin
              if (f[FL_LOOP]) begin
                f[FL_BOUNCING] = 1'b0;
                nx = n - 2;
              end else nx = n - 1;
            end
          end
          // one-frame bounce lands on -1
          if (nx < 0) nx = 0;
          else if (nx > n - 1) nx = n - 1;
          frame_cur = nx[FRAME_W-1:0];
          elapsed = elapsed - dur;
        end
        anim_flags[anim_seen] = f;
        count_ok = 1'b1;
      end
      FN_CTRL: begin
        f = anim_flags[t];
        case (cmd.ctrl_code)
          CC_PLAY: begin
            f[FL_PAUSED] = 1'b0;
            f[FL_REVERSE] = 1'b0;
            f[FL_KEEPFWD] = 1'b1;
          end
          CC_PAUSE: f[FL_PAUSED] = 1'b1;
          CC_REVERSE: begin
            f[FL_PAUSED] = 1'b0;
            f[FL_REVERSE] = 1'b1;
          end
          CC_RESET: begin
            f[FL_BOUNCING] = 1'b0;
            frame_cur = f[FL_REVERSE] ? FRAME_W'(n - 1) : '0;
          end
          CC_LOOP: f[FL_LOOP] = 1'b1;
          CC_NOLOOP: begin
            f[FL_LOOP] = 1'b0;
            f[FL_NOLOOP] = 1'b1;
          end
          CC_BOUNCE: f[FL_BOUNCE] = 1'b1;
          default: begin
            f[FL_BOUNCE] = 1'b0;
            f[FL_NOBOUNCE] = 1'b1;
          end
        endcase
        anim_flags[t] = f;
        count_ok = (t == anim_seen);
      end
      FN_SELECT: begin
        if (t >= na) rej = 1'b1;
        else if (t != anim_seen) begin
          anim_seen = t;
          frame_cur = anim_flags[t][FL_REVERSE] ? FRAME_W'(n - 1) : '0;
        end
        count_ok = (t == anim_seen);
      end
      FN_SET_FRAME: begin
        if (cmd.frame_index >= n) rej = 1'b1;
        else frame_cur = cmd.frame_index;
        count_ok = 1'b1;
      end
      FN_LOAD: begin
        if (t < na) begin
          f = anim_flags[t];
          if (cmd.default_loop && !f[FL_NOLOOP]) f[FL_LOOP] = 1'b1;
          if (cmd.default_bounce && !f[FL_NOBOUNCE]) f[FL_BOUNCE] = 1'b1;
          if (cmd.default_reverse && !f[FL_KEEPFWD]) f[FL_REVERSE] = 1'b1;
          anim_flags[t] = f;
          if (anim_seen >= na) anim_seen = ANIM_W'(na - 1);
          if (t == anim_seen && frame_cur >= n) frame_cur = FRAME_W'(n - 1);
        end
        count_ok = (t == anim_seen);
      end
      default: ;
    endcase

    f = anim_flags[anim_seen];
    at_end = (frame_cur == n - 1);
    at_zero = (frame_cur == 0);
    st.anim = anim_seen;
    st.frame = frame_cur;
    st.paused = f[FL_PAUSED];
    st.rejected = rej;
    if (f[FL_LOOP]) st.finished = 1'b0;
    else if (!f[FL_REVERSE]) st.finished = count_ok && (f[FL_BOUNCING] ? at_zero : at_end);
    else st.finished = count_ok && (f[FL_BOUNCING] ? at_end : at_zero);
    return st;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    frame_status_t want;
    if (rst) begin
      status_q.delete();
      for (int i = 0; i < 16; i++) anim_flags[i] = '0;
      anim_seen = '0;
      frame_cur = '0;
      elapsed = '0;
      anims_reg = NUM_ANIMS_RST;
      step_reg = STEP_TIME_RST;
      rate_reg = PLAY_RATE_RST;
    end else begin
      // result first: it can never belong to a command taken at this same edge
      if (rsp.valid && rsp.ready) begin
        if (status_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual anim %0d frame %0d",
                   $time, rsp.current_anim, rsp.current_frame);
          errors++;
        end else begin
          want = status_q.pop_front();
          compare_field("current_anim", want.anim, rsp.current_anim);
          compare_field("current_frame", want.frame, rsp.current_frame);
          compare_field("is_paused", want.paused, rsp.is_paused);
          compare_field("is_finished", want.finished, rsp.is_finished);
          compare_field("rejected", want.rejected, rsp.rejected);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          CFG_NUM_ANIMS: anims_reg = cfg.data[NANIM_W-1:0];
          CFG_STEP_TIME: step_reg = cfg.data[TIME_W-1:0];
          CFG_PLAY_RATE: rate_reg = cfg.data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) status_q = {status_q, predict_status()};
    end
    pending = status_q.size();
  end

endmodule

// File: tb/testbench.sv
module testbench;
  import sfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 90;
  localparam int NUM_PHASES  = 6;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 40;
  localparam logic [CFG_A_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [CODE_W-1:0]  ctrl_code;
    logic [ANIM_W-1:0]  target_anim;
    logic [FRAME_W-1:0] frame_index;
    logic [COUNT_W-1:0] frame_count;
    logic [TIME_W-1:0]  frame_duration;
    logic [2:0]         defaults;
  } cmd_item_t;

  logic clk;
  logic rst;
  int   err_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_cycles;
  int   cycle_count;
  int   anim_frames[16];
  logic [ANIM_W-1:0] anim_seen;

  sfs_cmd_if cmd_ch();
  sfs_rsp_if rsp_ch();
  sfs_cfg_if cfg_ch();

  sprite_frame_sequencer_unit uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  frame_status_monitor monitor (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch),
    .errors(err_count),
    .pending(pending),
    .anim_seen(anim_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // receiver: random idling, or a long hold-off when requested
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_ch.ready = 1'b0;
        hold_cycles--;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic cmd_item_t mk(input logic [FUNC_W-1:0] fn, input logic [CODE_W-1:0] code,
                                   input logic [ANIM_W-1:0] t, input logic [FRAME_W-1:0] fi,
                                   input logic [COUNT_W-1:0] fc, input logic [TIME_W-1:0] dur,
                                   input logic [2:0] defs);
    cmd_item_t it;
    it.func = fn;
    it.ctrl_code = code;
    it.target_anim = t;
    it.frame_index = fi;
    it.frame_count = fc;
    it.frame_duration = dur;
    it.defaults = defs;
    return it;
  endfunction

  task automatic send_cmd(input cmd_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid = 1'b1;
    cmd_ch.func = it.func;
    cmd_ch.ctrl_code = it.ctrl_code;
    cmd_ch.target_anim = it.target_anim;
    cmd_ch.frame_index = it.frame_index;
    cmd_ch.frame_count = it.frame_count;
    cmd_ch.frame_duration = it.frame_duration;
    {cmd_ch.default_loop, cmd_ch.default_bounce, cmd_ch.default_reverse} = it.defaults;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_A_W-1:0] a, input logic [CFG_D_W-1:0] d);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.addr = a;
    cfg_ch.data = d;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin
    cmd_item_t it;
    logic [NANIM_W-1:0] nanims;
    logic [TIME_W-1:0]  step_val;
    logic [RATE_W-1:0]  rate_val;
    int active;
    int pick;
    int cnt;

    rst = 1'b1;
    hold_cycles = 0;
    send_idle_pct = 12;
    recv_idle_pct = 65;
    cmd_ch.valid = 1'b0;
    cmd_ch.func = '0;
    cmd_ch.ctrl_code = '0;
    cmd_ch.target_anim = '0;
    cmd_ch.frame_index = '0;
    cmd_ch.frame_count = '0;
    cmd_ch.frame_duration = '0;
    cmd_ch.default_loop = 1'b0;
    cmd_ch.default_bounce = 1'b0;
    cmd_ch.default_reverse = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = '0;
    cfg_ch.data = '0;
    for (int i = 0; i < 16; i++) anim_frames[i] = $urandom_range(1, 8);
    anim_frames[$urandom_range(15)] = 1;
    anim_frames[$urandom_range(15)] = 256;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed part under the reset register values (one animation)
    send_cmd(mk(FN_SET_FRAME, CC_PLAY, 0, 0, 1, 0, 3'b000));
    send_cmd(mk(FN_SET_FRAME, CC_PLAY, 0, 1, 1, 0, 3'b000));
    send_cmd(mk(FN_SET_FRAME, CC_PLAY, 0, 255, 256, 0, 3'b000));
    send_cmd(mk(FN_SET_FRAME, CC_PLAY, 0, 200, 511, 0, 3'b000));
    send_cmd(mk(FN_CTRL, CC_BOUNCE, 0, 0, 1, 0, 3'b000));
    send_cmd(mk(FN_CTRL, CC_LOOP, 0, 0, 1, 0, 3'b000));
    // one-frame bounce with zero duration: step target goes negative
    send_cmd(mk(FN_TICK, CC_PLAY, 0, 0, 1, 0, 3'b000));
    send_cmd(mk(FN_TICK, CC_PLAY, 0, 0, 0, 1, 3'b000));
    send_cmd(mk(FN_SELECT, CC_PLAY, 1, 0, 4, 0, 3'b000));
    send_cmd(mk(FN_SELECT, CC_PLAY, 0, 0, 4, 0, 3'b000));
    send_cmd(mk(FN_CTRL, CC_REVERSE, 0, 0, 4, 0, 3'b000));
    send_cmd(mk(FN_TICK, CC_PLAY, 0, 0, 4, 500, 3'b000));
    send_cmd(mk(FN_CTRL, CC_RESET, 0, 0, 4, 0, 3'b000));
    send_cmd(mk(FN_CTRL, CC_RESET, 5, 0, 10, 0, 3'b000));
    send_cmd(mk(FN_CTRL, CC_PAUSE, 0, 0, 4, 0, 3'b000));
    send_cmd(mk(FN_TICK, CC_PLAY, 0, 0, 4, 300, 3'b000));
    send_cmd(mk(FN_CTRL, CC_PLAY, 0, 0, 4, 0, 3'b000));
    send_cmd(mk(FN_CTRL, CC_NOLOOP, 0, 0, 4, 0, 3'b000));
    send_cmd(mk(FN_CTRL, CC_NOBOUNCE, 0, 0, 4, 0, 3'b000));
    // overrides on animation 0 now block every default
    send_cmd(mk(FN_LOAD, CC_PLAY, 0, 0, 2, 0, 3'b111));
    send_cmd(mk(FN_LOAD, CC_PLAY, 3, 0, 2, 0, 3'b111));
    send_cmd(mk(FN_LOAD, CC_PLAY, 15, 0, 2, 0, 3'b111));
    send_cmd(mk(FN_TICK, CC_PLAY, 0, 0, 256, 32'hFFFF_FFFF, 3'b000));
    send_cmd(mk(3'd5, CC_NOBOUNCE, 15, 255, 511, $urandom, 3'b111));
    send_cmd(mk(3'd6, CC_PLAY, 0, 0, 0, 0, 3'b000));
    send_cmd(mk(3'd7, CC_PAUSE, 15, 0, 256, 0, 3'b101));
    send_cmd(mk(FN_CTRL, CC_PAUSE, 15, 0, 256, 0, 3'b000));

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin nanims = 16; step_val = 1092;          rate_val = 256;     end
        1: begin nanims = 0;  step_val = 0;             rate_val = 0;       end
        2: begin nanims = 31; step_val = 32'hFFFF_FFFF; rate_val = 16'hFFFF; end
        3: begin
          nanims = 5;
          step_val = $urandom_range(500, 6000);
          rate_val = $urandom_range(64, 1024);
        end
        4: begin nanims = 16; step_val = 20000;         rate_val = 1;       end
        default: begin nanims = 12; step_val = $urandom; rate_val = $urandom; end
      endcase
      if (p < 2) begin
        send_idle_pct = 12;
        recv_idle_pct = 65;
      end else if (p < 4) begin
        send_idle_pct = 65;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_reg(CFG_NUM_ANIMS, ($urandom & ~32'h1F) | 32'(nanims));
      set_reg(CFG_STEP_TIME, step_val);
      set_reg(CFG_PLAY_RATE, ($urandom & 32'hFFFF_0000) | 32'(rate_val));
      if (p == 0) set_reg(CFG_SPARE, $urandom);
      active = (nanims == 0) ? 1 : (nanims > 16) ? 16 : nanims;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long receiver stall while commands keep coming
        if (p == 0 && i == 20) hold_cycles = HOLD_CYCLES;
        pick = $urandom_range(99);
        it.ctrl_code = $urandom_range(7);
        it.target_anim = ($urandom_range(9) < 7) ? $urandom_range(active - 1) : $urandom_range(15);
        it.defaults = $urandom_range(7);
        if (pick < 45) it.func = FN_TICK;
        else if (pick < 63) it.func = FN_CTRL;
        else if (pick < 75) it.func = FN_SELECT;
        else if (pick < 84) it.func = FN_SET_FRAME;
        else if (pick < 94) it.func = FN_LOAD;
        else it.func = $urandom_range(5, 7);
        if (it.func == FN_TICK || it.func == FN_SET_FRAME) cnt = anim_frames[anim_seen];
        else cnt = anim_frames[it.target_anim];
        pick = $urandom_range(19);
        if (pick == 0) it.frame_count = $urandom_range(511);
        else if (pick == 1) begin
          case ($urandom_range(3))
            0: it.frame_count = 0;
            1: it.frame_count = 1;
            2: it.frame_count = 256;
            default: it.frame_count = 511;
          endcase
        end else it.frame_count = cnt;
        it.frame_index = ($urandom_range(3) != 0) ? $urandom_range(cnt - 1) : $urandom_range(255);
        pick = $urandom_range(19);
        if (pick < 12) it.frame_duration = $urandom_range(200, 5000);
        else if (pick < 15) it.frame_duration = $urandom_range(1);
        else if (pick < 18) it.frame_duration = $urandom;
        else it.frame_duration = 32'hFFFF_FFFF;
        send_cmd(it);
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
